/* rtl/gcib_pkg.sv */
// Shared constants, types and elaboration-time table functions for the bearing pipeline.
package gcib_pkg;

    localparam int ANGLE_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int IN_FRAC           = 23;
    localparam int VEC_FRAC          = 30;
    localparam int RAD_FRAC          = 50;
    localparam int LAT_W             = 31;
    localparam int LON_W             = 32;
    localparam int BEAR_W            = 32;
    localparam int VW                = 34;
    localparam int VXW               = 36;
    localparam int MW                = 32;
    localparam int LANES             = 3;
    localparam int LANE_LAT1         = 0;
    localparam int LANE_LAT2         = 1;
    localparam int LANE_DLON         = 2;
    localparam int FIFO_DEPTH        = 2;

    localparam logic signed [63:0]       PI_Q60        = 64'sh3243F6A8885A308D;
    localparam logic signed [BEAR_W-1:0] BEARING_LIMIT = 32'sd1509949440;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_side;

    // Stage angle atan(2^-idx) in degrees with af fraction bits, rounded half up.
    function automatic logic signed [63:0] f_stage_angle(input int idx, input int af);
        logic signed [63:0] rad;
        logic signed [63:0] t;
        logic signed [63:0] n;
        logic signed [63:0] q;
        logic signed [63:0] r;
        int k;
        int e;
        int b;
        if (idx == 0) begin
            return 64'sd45 <<< af;
        end
        rad = '0;
        k   = 0;
        e   = RAD_FRAC - idx;
        while (e >= 0) begin
            t = (64'sd1 <<< e) / 64'(2 * k + 1);
            if (k[0]) begin
                rad = rad - t;
            end else begin
                rad = rad + t;
            end
            k = k + 1;
            e = RAD_FRAC - idx * (2 * k + 1);
        end
        n = rad * 64'sd180;
        q = n / PI_Q60;
        r = n % PI_Q60;
        for (b = 0; b < af + (60 - RAD_FRAC) + 1; b++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= PI_Q60) begin
                r = r - PI_Q60;
                q = q | 64'sd1;
            end
        end
        return (q + 64'sd1) >>> 1;
    endfunction

    // Gain that a vectoring CORDIC leaves on a unit vector, at least one.
    function automatic logic signed [63:0] f_gain(input int stages);
        logic signed [63:0] gx;
        logic signed [63:0] gy;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        int i;
        gx = 64'sd1 <<< VEC_FRAC;
        gy = '0;
        for (i = 0; i < stages; i++) begin
            dx = gy >>> i;
            dy = gx >>> i;
            if (gy >= 0) begin
                gx = gx + dx;
                gy = gy - dy;
            end else begin
                gx = gx - dx;
                gy = gy + dy;
            end
        end
        if (gx < 64'sd1) begin
            gx = 64'sd1;
        end
        return gx;
    endfunction

endpackage

/* rtl/gcib_if.sv */
// Request and result channel interfaces of the bearing block.
interface gcib_in_if;
    import gcib_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] own_latitude;
    logic signed [LON_W-1:0] own_longitude;
    logic signed [LAT_W-1:0] target_latitude;
    logic signed [LON_W-1:0] target_longitude;

    modport source (
        output valid, own_latitude, own_longitude, target_latitude, target_longitude,
        input  ready
    );
    modport sink (
        input  valid, own_latitude, own_longitude, target_latitude, target_longitude,
        output ready
    );
endinterface

interface gcib_out_if;
    import gcib_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [BEAR_W-1:0] bearing;

    modport source (output valid, bearing, input ready);
    modport sink (input valid, bearing, output ready);
endinterface

/* rtl/gcib_rot.sv */
// Three-lane pipelined rotation CORDIC giving sine and cosine of the latitudes and dLon.
module gcib_rot #(
    parameter int AW     = gcib_pkg::ANGLE_WIDTH_DEF,
    parameter int STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  gcib_pkg::t_side                i_side,
    input  logic signed [AW-1:0]           i_z   [gcib_pkg::LANES],
    output gcib_pkg::t_side                o_side,
    output logic signed [gcib_pkg::VW-1:0] o_sin [gcib_pkg::LANES],
    output logic signed [gcib_pkg::VW-1:0] o_cos [gcib_pkg::LANES]
);
    import gcib_pkg::*;

    localparam int                    AF      = AW - 9;
    localparam logic signed [AW-1:0]  HALF    = AW'(180) <<< AF;
    localparam logic signed [AW-1:0]  QUARTER = AW'(90) <<< AF;
    localparam logic signed [VW-1:0]  START   = VW'((64'sd1 <<< 60) / f_gain(STAGES));

    t_side r_side [STAGES+2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES + 2; i++) begin
                r_side[i] <= '0;
            end
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < STAGES + 2; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_side = r_side[STAGES+1];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [AW-1:0] r_zf;
        logic                 r_ff;
        logic signed [VW-1:0] r_s;
        logic signed [VW-1:0] r_c;
        wire signed [VW-1:0]  w_x [STAGES+1];
        wire signed [VW-1:0]  w_y [STAGES+1];
        wire signed [AW-1:0]  w_z [STAGES+1];
        wire                  w_f [STAGES+1];

        // Angles beyond a quarter turn are moved by a half turn and the result negated.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_z[l] > QUARTER) begin
                    r_zf <= i_z[l] - HALF;
                    r_ff <= 1'b1;
                end else if (i_z[l] < -QUARTER) begin
                    r_zf <= i_z[l] + HALF;
                    r_ff <= 1'b1;
                end else begin
                    r_zf <= i_z[l];
                    r_ff <= 1'b0;
                end
            end
        end

        assign w_x[0] = START;
        assign w_y[0] = '0;
        assign w_z[0] = r_zf;
        assign w_f[0] = r_ff;

        for (genvar g = 0; g < STAGES; g++) begin : g_stage
            localparam logic signed [AW-1:0] ANG = AW'(f_stage_angle(g, AF));
            logic signed [VW-1:0] r_x;
            logic signed [VW-1:0] r_y;
            logic signed [AW-1:0] r_z;
            logic                 r_f;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_z[g] >= 0) begin
                        r_x <= w_x[g] - (w_y[g] >>> g);
                        r_y <= w_y[g] + (w_x[g] >>> g);
                        r_z <= w_z[g] - ANG;
                    end else begin
                        r_x <= w_x[g] + (w_y[g] >>> g);
                        r_y <= w_y[g] - (w_x[g] >>> g);
                        r_z <= w_z[g] + ANG;
                    end
                    r_f <= w_f[g];
                end
            end

            assign w_x[g+1] = r_x;
            assign w_y[g+1] = r_y;
            assign w_z[g+1] = r_z;
            assign w_f[g+1] = r_f;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s <= w_f[STAGES] ? -w_y[STAGES] : w_y[STAGES];
                r_c <= w_f[STAGES] ? -w_x[STAGES] : w_x[STAGES];
            end
        end

        assign o_sin[l] = r_s;
        assign o_cos[l] = r_c;
    end
endmodule

/* rtl/gcib_mix.sv */
// Product stages forming the two atan2 operands from the sines and cosines.
module gcib_mix (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  gcib_pkg::t_side                i_side,
    input  logic signed [gcib_pkg::VW-1:0] i_sin [gcib_pkg::LANES],
    input  logic signed [gcib_pkg::VW-1:0] i_cos [gcib_pkg::LANES],
    output gcib_pkg::t_side                o_side,
    output logic signed [gcib_pkg::VW-1:0] o_x,
    output logic signed [gcib_pkg::VW-1:0] o_y
);
    import gcib_pkg::*;

    logic signed [2*MW-1:0] m_y;
    logic signed [2*MW-1:0] m_a;
    logic signed [2*MW-1:0] m_b;
    logic signed [2*MW-1:0] m_c;
    logic signed [VW-1:0]   r_py1;
    logic signed [VW-1:0]   r_pa1;
    logic signed [VW-1:0]   r_pb1;
    logic signed [VW-1:0]   r_cd1;
    logic signed [VW-1:0]   r_py2;
    logic signed [VW-1:0]   r_pa2;
    logic signed [VW-1:0]   r_pc2;
    logic signed [VW-1:0]   r_x;
    logic signed [VW-1:0]   r_y;
    logic signed [VW-1:0]   n_x;
    t_side                  r_side [3];

    always_comb begin
        m_y = $signed(i_sin[LANE_DLON][MW-1:0]) * $signed(i_cos[LANE_LAT2][MW-1:0]);
        m_a = $signed(i_cos[LANE_LAT1][MW-1:0]) * $signed(i_sin[LANE_LAT2][MW-1:0]);
        m_b = $signed(i_sin[LANE_LAT1][MW-1:0]) * $signed(i_cos[LANE_LAT2][MW-1:0]);
        m_c = $signed(r_pb1[MW-1:0]) * $signed(r_cd1[MW-1:0]);
        n_x = r_pa2 - r_pc2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_py1 <= VW'(m_y >>> VEC_FRAC);
            r_pa1 <= VW'(m_a >>> VEC_FRAC);
            r_pb1 <= VW'(m_b >>> VEC_FRAC);
            r_cd1 <= i_cos[LANE_DLON];
            r_py2 <= r_py1;
            r_pa2 <= r_pa1;
            r_pc2 <= VW'(m_c >>> VEC_FRAC);
            r_x   <= n_x;
            r_y   <= r_py2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
            r_side[1] <= '0;
            r_side[2] <= '0;
        end else if (i_en) begin
            r_side[0]       <= i_side;
            r_side[1]       <= r_side[0];
            r_side[2].valid <= r_side[1].valid;
            r_side[2].zero  <= r_side[1].zero || ((n_x == '0) && (r_py2 == '0));
        end
    end

    assign o_side = r_side[2];
    assign o_x    = r_x;
    assign o_y    = r_y;
endmodule

/* rtl/gcib_vec.sv */
// Pipelined vectoring CORDIC for atan2, with rounding and saturation of the bearing.
module gcib_vec #(
    parameter int AW     = gcib_pkg::ANGLE_WIDTH_DEF,
    parameter int STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  gcib_pkg::t_side                    i_side,
    input  logic signed [gcib_pkg::VW-1:0]     i_x,
    input  logic signed [gcib_pkg::VW-1:0]     i_y,
    output gcib_pkg::t_side                    o_side,
    output logic signed [gcib_pkg::BEAR_W-1:0] o_bearing
);
    import gcib_pkg::*;

    localparam int                    AF    = AW - 9;
    localparam int                    ZV    = AW + 1;
    localparam logic signed [ZV-1:0]  HALF  = ZV'(180) <<< AF;
    localparam int                    DOWN  = AF - IN_FRAC;
    localparam int                    DP    = (DOWN > 0) ? DOWN : 0;
    localparam int                    UPB   = (DOWN < 0) ? -DOWN : 0;
    localparam int                    HS    = (DOWN > 0) ? DOWN - 1 : 0;
    localparam int                    ZW    = AW + UPB + 2;
    localparam logic signed [ZW-1:0]  HALFB = (DOWN > 0) ? (ZW'(1) <<< HS) : ZW'(0);
    localparam logic signed [ZW-1:0]  LIM   = ZW'(BEARING_LIMIT);

    t_side                    r_side [STAGES+2];
    logic signed [VXW-1:0]    r_xf;
    logic signed [VXW-1:0]    r_yf;
    logic signed [ZV-1:0]     r_zf;
    logic signed [BEAR_W-1:0] r_b;
    logic signed [ZW-1:0]     n_sc;
    logic signed [BEAR_W-1:0] n_b;
    wire signed [VXW-1:0]     w_x [STAGES+1];
    wire signed [VXW-1:0]     w_y [STAGES+1];
    wire signed [ZV-1:0]      w_z [STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES + 2; i++) begin
                r_side[i] <= '0;
            end
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < STAGES + 2; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // A vector in the left half plane is turned by a half turn first.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_xf <= -VXW'(i_x);
                r_yf <= -VXW'(i_y);
                r_zf <= (i_y >= 0) ? HALF : -HALF;
            end else begin
                r_xf <= VXW'(i_x);
                r_yf <= VXW'(i_y);
                r_zf <= '0;
            end
        end
    end

    assign w_x[0] = r_xf;
    assign w_y[0] = r_yf;
    assign w_z[0] = r_zf;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic signed [ZV-1:0] ANG = ZV'(f_stage_angle(g, AF));
        logic signed [VXW-1:0] r_x;
        logic signed [VXW-1:0] r_y;
        logic signed [ZV-1:0]  r_z;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y[g] >= 0) begin
                    r_x <= w_x[g] + (w_y[g] >>> g);
                    r_y <= w_y[g] - (w_x[g] >>> g);
                    r_z <= w_z[g] + ANG;
                end else begin
                    r_x <= w_x[g] - (w_y[g] >>> g);
                    r_y <= w_y[g] + (w_x[g] >>> g);
                    r_z <= w_z[g] - ANG;
                end
            end
        end

        assign w_x[g+1] = r_x;
        assign w_y[g+1] = r_y;
        assign w_z[g+1] = r_z;
    end

    always_comb begin
        n_sc = ((ZW'(w_z[STAGES]) + HALFB) >>> DP) <<< UPB;
        if (r_side[STAGES].zero) begin
            n_b = '0;
        end else if (n_sc > LIM) begin
            n_b = BEARING_LIMIT;
        end else if (n_sc < -LIM) begin
            n_b = -BEARING_LIMIT;
        end else begin
            n_b = BEAR_W'(n_sc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
        end
    end

    assign o_side    = r_side[STAGES+1];
    assign o_bearing = r_b;
endmodule

/* rtl/great_circle_initial_bearing.sv */
// Initial great-circle bearing pipeline: one request per cycle, no stored state.
// A request runs through the input and reduction stages, the rotation CORDIC, the product
// stages and the vectoring CORDIC, and its result then waits in a two-entry output queue.
// Throughput is one request per cycle; the pipeline holds only while the output queue is full
// and its head result is not taken.
// Synchronous active-low reset clears the valid bits and the output queue.
module great_circle_initial_bearing #(
    parameter int ANGLE_WIDTH   = gcib_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    gcib_in_if.sink    i_req,
    gcib_out_if.source o_res
);
    import gcib_pkg::*;

    localparam int                   AW   = ANGLE_WIDTH;
    localparam int                   AF   = AW - 9;
    localparam int                   UP   = AF - IN_FRAC;
    localparam int                   UPS  = (UP > 0) ? UP : 0;
    localparam int                   DNS  = (UP < 0) ? -UP : 0;
    localparam int                   TW   = LON_W + 2 + UPS;
    localparam int                   DW   = AW + 2;
    localparam logic signed [DW-1:0] HALF = DW'(180) <<< AF;
    localparam logic signed [DW-1:0] FULL = DW'(360) <<< AF;

    logic                     en;
    logic signed [TW-1:0]     t_lat1;
    logic signed [TW-1:0]     t_lat2;
    logic signed [TW-1:0]     t_dl;
    logic signed [DW-1:0]     n_dlon;
    logic signed [AW-1:0]     r_lat1_0;
    logic signed [AW-1:0]     r_lat2_0;
    logic signed [DW-1:0]     r_dl_0;
    logic                     r_vld_0;
    logic signed [AW-1:0]     r_z1 [LANES];
    t_side                    r_side_1;
    t_side                    rot_side;
    t_side                    mix_side;
    t_side                    vec_side;
    logic signed [VW-1:0]     rot_sin [LANES];
    logic signed [VW-1:0]     rot_cos [LANES];
    logic signed [VW-1:0]     mix_x;
    logic signed [VW-1:0]     mix_y;
    logic signed [BEAR_W-1:0] vec_bearing;
    logic signed [BEAR_W-1:0] r_fifo [FIFO_DEPTH];
    logic                     r_wr;
    logic                     r_rd;
    logic [1:0]               r_cnt;
    logic                     push;
    logic                     pop;

    assign en          = (r_cnt != 2'(FIFO_DEPTH)) || o_res.ready;
    assign i_req.ready = en;
    assign push        = en && vec_side.valid;
    assign pop         = o_res.valid && o_res.ready;

    always_comb begin
        t_lat1 = (TW'(i_req.own_latitude) <<< UPS) >>> DNS;
        t_lat2 = (TW'(i_req.target_latitude) <<< UPS) >>> DNS;
        t_dl   = ((TW'(i_req.target_longitude) - TW'(i_req.own_longitude)) <<< UPS) >>> DNS;
        if (r_dl_0 >= HALF) begin
            n_dlon = r_dl_0 - FULL;
        end else if (r_dl_0 < -HALF) begin
            n_dlon = r_dl_0 + FULL;
        end else begin
            n_dlon = r_dl_0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat1_0        <= AW'(t_lat1);
            r_lat2_0        <= AW'(t_lat2);
            r_dl_0          <= DW'(t_dl);
            r_z1[LANE_LAT1] <= r_lat1_0;
            r_z1[LANE_LAT2] <= r_lat2_0;
            r_z1[LANE_DLON] <= AW'(n_dlon);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_0  <= 1'b0;
            r_side_1 <= '0;
        end else if (en) begin
            r_vld_0        <= i_req.valid;
            r_side_1.valid <= r_vld_0;
            r_side_1.zero  <= (r_lat1_0 == r_lat2_0) && (n_dlon == '0);
        end
    end

    gcib_rot #(
        .AW     (AW),
        .STAGES (CORDIC_STAGES)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_side_1),
        .i_z     (r_z1),
        .o_side  (rot_side),
        .o_sin   (rot_sin),
        .o_cos   (rot_cos)
    );

    gcib_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (rot_side),
        .i_sin   (rot_sin),
        .i_cos   (rot_cos),
        .o_side  (mix_side),
        .o_x     (mix_x),
        .o_y     (mix_y)
    );

    gcib_vec #(
        .AW     (AW),
        .STAGES (CORDIC_STAGES)
    ) u_vec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_side    (mix_side),
        .i_x       (mix_x),
        .i_y       (mix_y),
        .o_side    (vec_side),
        .o_bearing (vec_bearing)
    );

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr] <= vec_bearing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_res.valid   = (r_cnt != '0);
    assign o_res.bearing = r_fifo[r_rd];
endmodule

/* rtl/gcib_chk.sv */
// Port-level assertions for the bearing block, bound to the top level.
module gcib_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [gcib_pkg::BEAR_W-1:0] i_bearing
);
    import gcib_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bearing))
        else $error("result changed or dropped while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_bearing <= BEARING_LIMIT) && (i_bearing >= -BEARING_LIMIT))
        else $error("bearing outside half-turn range");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request refused with empty output queue");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("request held back while results can move");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");
endmodule

bind great_circle_initial_bearing gcib_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_bearing   (o_res.bearing)
);

/* tb/tb_great_circle_initial_bearing.sv */
// Self-checking testbench for the great-circle initial bearing pipeline.
`timescale 1ns / 100ps

module tb_great_circle_initial_bearing;
    import gcib_pkg::*;

    localparam int       STAGES   = CORDIC_STAGES_DEF;
    localparam int       AF       = ANGLE_WIDTH_DEF - 9;
    localparam longint   LAT_MAX  = 754974720;
    localparam longint   LON_MAX  = 1509949440;
    localparam longint   DEG      = longint'(1) << IN_FRAC;
    localparam int       DRAIN    = 2 * STAGES + 20;

    class bearing_scoreboard;
        longint                   atan_deg[STAGES];
        longint                   gain_start;
        logic signed [BEAR_W-1:0] pending[$];
        int                       errors;

        function new();
            longint rad;
            longint t;
            longint n;
            longint q;
            longint r;
            longint gx;
            longint gy;
            longint gz;
            int     e;
            errors      = 0;
            atan_deg[0] = longint'(45) <<< AF;
            for (int i = 1; i < STAGES; i++) begin
                rad = 0;
                for (int k = 0; RAD_FRAC - i * (2 * k + 1) >= 0; k++) begin
                    e = RAD_FRAC - i * (2 * k + 1);
                    t = (longint'(1) <<< e) / (2 * k + 1);
                    rad = k[0] ? rad - t : rad + t;
                end
                n = rad * 180;
                q = n / PI_Q60;
                r = n % PI_Q60;
                for (int j = 0; j < AF + (60 - RAD_FRAC) + 1; j++) begin
                    r = r <<< 1;
                    q = q <<< 1;
                    if (r >= PI_Q60) begin
                        r = r - PI_Q60;
                        q = q | 1;
                    end
                end
                atan_deg[i] = (q + 1) >>> 1;
            end
            gx = longint'(1) <<< VEC_FRAC;
            gy = 0;
            gz = 0;
            vectoring(gx, gy, gz);
            if (gx < 1) gx = 1;
            gain_start = (longint'(1) <<< 60) / gx;
        endfunction

        function void vectoring(inout longint x, inout longint y, inout longint z);
            longint dx;
            longint dy;
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx; y = y - dy; z = z + atan_deg[i];
                end else begin
                    x = x - dx; y = y + dy; z = z - atan_deg[i];
                end
            end
        endfunction

        function longint wrap(longint a);
            longint full;
            longint r;
            full = longint'(360) <<< AF;
            r = a % full;
            if (r < 0) r = r + full;
            if (r >= full / 2) r = r - full;
            return r;
        endfunction

        function void rotate(longint a, output longint s, output longint c);
            longint half;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            bit     flip;
            half = longint'(180) <<< AF;
            x    = gain_start;
            y    = 0;
            z    = wrap(a);
            flip = 0;
            if (z > half / 2) begin
                z = z - half; flip = 1;
            end else if (z < -half / 2) begin
                z = z + half; flip = 1;
            end
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - atan_deg[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + atan_deg[i];
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function longint mulq(longint a, longint b);
            return (a * b) >>> VEC_FRAC;
        endfunction

        function logic signed [BEAR_W-1:0] bearing_of(longint la1, longint lo1,
                                                      longint la2, longint lo2);
            longint dl, s1, c1, s2, c2, sd, cd, x, y, z;
            dl = wrap(lo2 - lo1);
            if (la1 == la2 && dl == 0) return '0;
            rotate(la1, s1, c1);
            rotate(la2, s2, c2);
            rotate(dl, sd, cd);
            y = mulq(sd, c2);
            x = mulq(c1, s2) - mulq(mulq(s1, c2), cd);
            if (x == 0 && y == 0) return '0;
            z = 0;
            if (x < 0) begin
                z = (y >= 0 ? longint'(180) : longint'(-180)) <<< AF;
                x = -x;
                y = -y;
            end
            vectoring(x, y, z);
            if (z > BEARING_LIMIT) z = BEARING_LIMIT;
            if (z < -BEARING_LIMIT) z = -BEARING_LIMIT;
            return z[BEAR_W-1:0];
        endfunction

        function void note(longint la1, longint lo1, longint la2, longint lo2);
            pending.push_back(bearing_of(la1, lo1, la2, lo2));
        endfunction

        function void check(logic signed [BEAR_W-1:0] actual);
            logic signed [BEAR_W-1:0] want;
            if (pending.size() == 0) begin
                if (errors < 10) $display("Unexpected result: bearing %0d", actual);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (actual !== want) begin
                if (errors < 10) $display("Bearing mismatch: expected %0d, got %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;

    gcib_in_if  req_if ();
    gcib_out_if res_if ();

    great_circle_initial_bearing i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    bearing_scoreboard sb = new();

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) sb.check(res_if.bearing);
        res_if.ready <= calm || ($urandom_range(99) >= 19);
    end

    function automatic longint rand_lat();
        return longint'($urandom_range(32'(2 * LAT_MAX))) - LAT_MAX;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(32'(2 * LON_MAX))) - LON_MAX;
    endfunction

    task automatic send_request(longint la1, longint lo1, longint la2, longint lo2);
        while (!calm && $urandom_range(99) < 19) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid            <= 1'b1;
        req_if.own_latitude     <= la1[LAT_W-1:0];
        req_if.own_longitude    <= lo1[LON_W-1:0];
        req_if.target_latitude  <= la2[LAT_W-1:0];
        req_if.target_longitude <= lo2[LON_W-1:0];
        do @(posedge i_clk); while (!req_if.ready);
        sb.note(la1, lo1, la2, lo2);
    endtask

    initial begin
        longint la1, lo1, la2, lo2;
        int     pick;
        i_rst_n                 = 1'b0;
        calm                    = 1'b0;
        req_if.valid            = 1'b0;
        req_if.own_latitude     = '0;
        req_if.own_longitude    = '0;
        req_if.target_latitude  = '0;
        req_if.target_longitude = '0;
        res_if.ready            = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes, poles, same position, wrap of the longitude difference, and southward cases.
        send_request(0, 0, 0, 0);
        send_request(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
        send_request(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX);
        send_request(10 * DEG, -LON_MAX, 10 * DEG, LON_MAX);
        send_request(-LAT_MAX, 0, LAT_MAX, 0);
        send_request(LAT_MAX, 0, -LAT_MAX, 0);
        send_request(0, 0, 0, LON_MAX);
        send_request(0, -LON_MAX, 0, LON_MAX - 1);
        send_request(0, 0, 0, 90 * DEG);
        send_request(0, 0, 0, -90 * DEG);
        send_request(LAT_MAX, 0, 0, 45 * DEG);
        send_request(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_request(45 * DEG, 0, 0, 0);
        send_request(-45 * DEG, 0, -80 * DEG, 1);
        send_request(30 * DEG, 0, 30 * DEG, -1);
        send_request(-1, -1, 1, 1);
        send_request(LAT_MAX - 1, LON_MAX - 1, -LAT_MAX + 1, -LON_MAX + 1);
        send_request(60 * DEG, 170 * DEG, 60 * DEG, -170 * DEG);
        send_request(20 * DEG, 0, -20 * DEG, LON_MAX);
        send_request(0, LON_MAX, 0, -LON_MAX);

        // Hold off until the pipeline is empty.
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        for (int n = 0; n < 1000; n++) begin
            calm = (n >= 300 && n < 500);
            pick = $urandom_range(9);
            la1 = rand_lat();
            lo1 = rand_lon();
            la2 = (pick == 0) ? la1 : rand_lat();
            lo2 = (pick <= 1) ? lo1 + longint'($urandom_range(2000)) - 1000 :
                  (pick == 2) ? lo1 + longint'($urandom_range(20 * DEG)) - 10 * DEG :
                  rand_lon();
            if (lo2 > LON_MAX) lo2 = LON_MAX;
            if (lo2 < -LON_MAX) lo2 = -LON_MAX;
            send_request(la1, lo1, la2, lo2);
        end
        calm = 1'b0;
        req_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
